### rtl/tgp_pkg.sv
package tgp_pkg;

    // Field and register widths
    localparam int OUT_W       = 24;
    localparam int BASE_W      = 24;
    localparam int COORD_W     = 12;
    localparam int CHAR_W      = 8;
    localparam int BPP_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Internal arithmetic widths
    localparam int IDX_W       = 6;
    localparam int SUM_W       = COORD_W + 1;
    localparam int PROD_W      = SUM_W + COORD_W;
    localparam int LIN_W       = PROD_W + 1;
    localparam int OFF_W       = LIN_W + BPP_W;
    localparam int GLYPH_OFF_W = IDX_W + 3 + BPP_W;
    localparam int LWB_W       = COORD_W + BPP_W;
    localparam int NL_STEP_W   = LWB_W + 3;
    localparam int STEP8_W     = BPP_W + 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Reset values of the configuration registers
    localparam logic [COORD_W-1:0] LINE_WIDTH_RESET = 12'd320;
    localparam logic [BPP_W-1:0]   BPP_RESET        = 2'd1;

    // Special character codes
    localparam logic [CHAR_W-1:0] CHR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_NEWLINE = 8'h40;

    // Glyph slots
    localparam logic [IDX_W-1:0] IDX_DIGIT_BASE = 6'd27;
    localparam logic [IDX_W-1:0] IDX_UNKNOWN    = 6'd43;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_BASE = 3'd0,
        REG_FONT_BASE   = 3'd1,
        REG_LINE_WIDTH  = 3'd2,
        REG_ORIGIN_X    = 3'd3,
        REG_ORIGIN_Y    = 3'd4,
        REG_BPP         = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NUL     = 2'd0,
        KIND_NEWLINE = 2'd1,
        KIND_SPACE   = 2'd2,
        KIND_GLYPH   = 2'd3
    } char_kind_t;

    typedef struct packed {
        logic               first_of_string;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [CHAR_W-1:0]  char_code;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] glyph_address;
        logic [OUT_W-1:0] dest_address;
        logic             address_overflow;
    } result_t;

    typedef struct packed {
        logic [BASE_W-1:0]  screen_base;
        logic [BASE_W-1:0]  font_base;
        logic [COORD_W-1:0] line_width;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [BPP_W-1:0]   bytes_per_pixel;
    } cfg_t;

    // Classified command passed from front to back
    typedef struct packed {
        char_kind_t       kind;
        logic             first;
        logic             load_wrap;
        logic             glyph_wrap;
        logic [OUT_W-1:0] glyph_address;
    } cmd_t;

    function automatic char_kind_t char_kind(input logic [CHAR_W-1:0] c);
        char_kind_t k;
        unique case (c)
            CHR_NUL:     k = KIND_NUL;
            CHR_NEWLINE: k = KIND_NEWLINE;
            CHR_SPACE:   k = KIND_SPACE;
            default:     k = KIND_GLYPH;
        endcase
        return k;
    endfunction

    // Font slot of a character: letters fold case, digits start at IDX_DIGIT_BASE
    function automatic logic [IDX_W-1:0] glyph_index(input logic [CHAR_W-1:0] c);
        logic [IDX_W-1:0] idx;
        unique case (c) inside
            [8'h41:8'h5A]: idx = IDX_W'(c - 8'h41);
            [8'h61:8'h7A]: idx = IDX_W'(c - 8'h61);
            [8'h30:8'h39]: idx = IDX_W'(c - 8'h30) + IDX_DIGIT_BASE;
            8'h21:         idx = 6'd37;   // !
            8'h3B:         idx = 6'd38;   // ;
            8'h3A:         idx = 6'd39;   // :
            8'h27:         idx = 6'd40;   // apostrophe
            8'h2D:         idx = 6'd41;   // -
            8'h2E:         idx = 6'd42;   // .
            8'h3F:         idx = 6'd43;   // ?
            8'h3C:         idx = 6'd44;   // <
            8'h3E:         idx = 6'd45;   // >
            8'h26:         idx = 6'd46;   // &
            8'h2A:         idx = 6'd47;   // *
            8'h28:         idx = 6'd48;   // (
            8'h29:         idx = 6'd49;   // )
            8'h23:         idx = 6'd50;   // #
            8'h5F:         idx = 6'd51;   // _
            8'h3D:         idx = 6'd52;   // =
            8'h5B:         idx = 6'd53;   // [
            8'h5D:         idx = 6'd54;   // ]
            8'h7C:         idx = 6'd55;   // |
            default:       idx = IDX_UNKNOWN;
        endcase
        return idx;
    endfunction

endpackage

### rtl/tgp_front.sv
module tgp_front #(
    parameter int AW = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  tgp_pkg::item_t  item,
    input  tgp_pkg::cfg_t   cfg,
    output logic            push,
    output tgp_pkg::cmd_t   push_cmd,
    output logic [AW-1:0]   push_load,
    input  logic            queue_full
);
    import tgp_pkg::*;

    localparam int XW = ((AW > OFF_W) ? AW : OFF_W) + 2;

    logic adv1;
    logic adv2;
    logic adv3;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;

    // Stage 1: row product and classification
    logic [SUM_W-1:0]  ysum;
    logic [PROD_W-1:0] s1_prod_reg, s1_prod_next;
    logic [SUM_W-1:0]  s1_xsum_reg, s1_xsum_next;
    logic              s1_first_reg;
    char_kind_t        s1_kind_reg, s1_kind_next;
    logic [IDX_W-1:0]  s1_idx_reg, s1_idx_next;

    // Stage 2: byte offsets
    logic [LIN_W-1:0]       lin;
    logic [OFF_W-1:0]       s2_off_reg, s2_off_next;
    logic [GLYPH_OFF_W-1:0] s2_goff_reg, s2_goff_next;
    logic                   s2_first_reg;
    char_kind_t             s2_kind_reg;

    // Stage 3: absolute addresses and wrap flags
    logic [XW-1:0] off_ext;
    logic [XW-1:0] load_sum;
    logic [XW-1:0] glyph_sum;
    cmd_t          s3_cmd_reg, s3_cmd_next;
    logic [AW-1:0] s3_load_reg, s3_load_next;

    // Advance each stage when the one after it frees up
    assign adv3       = !s3_valid_reg || !queue_full;
    assign adv2       = !s2_valid_reg || adv3;
    assign adv1       = !s1_valid_reg || adv2;
    assign item_stall = !adv1;
    assign push       = s3_valid_reg && !queue_full;

    assign s1_valid_next = adv1 ? item_valid   : s1_valid_reg;
    assign s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = adv3 ? s2_valid_reg : s3_valid_reg;

    always_comb
    begin
        ysum         = SUM_W'(cfg.origin_y) + SUM_W'(item.pos_y);
        s1_prod_next = PROD_W'(ysum) * PROD_W'(cfg.line_width);
        s1_xsum_next = SUM_W'(cfg.origin_x) + SUM_W'(item.pos_x);
        s1_kind_next = char_kind(item.char_code);
        s1_idx_next  = glyph_index(item.char_code);
    end

    always_comb
    begin
        lin          = LIN_W'(s1_prod_reg) + LIN_W'(s1_xsum_reg);
        s2_off_next  = OFF_W'(lin) * OFF_W'(cfg.bytes_per_pixel);
        s2_goff_next = GLYPH_OFF_W'({s1_idx_reg, 3'b000})
                       * GLYPH_OFF_W'(cfg.bytes_per_pixel);
    end

    always_comb
    begin
        off_ext   = XW'(s2_off_reg);
        load_sum  = XW'(cfg.screen_base) + XW'(off_ext[AW-1:0]);
        glyph_sum = XW'(cfg.font_base) + XW'(s2_goff_reg);

        s3_load_next              = load_sum[AW-1:0];
        s3_cmd_next.kind          = s2_kind_reg;
        s3_cmd_next.first         = s2_first_reg;
        s3_cmd_next.load_wrap     = (|off_ext[XW-1:AW]) || (|load_sum[XW-1:AW]);
        s3_cmd_next.glyph_wrap    = |glyph_sum[XW-1:AW];
        s3_cmd_next.glyph_address = OUT_W'(glyph_sum[AW-1:0]);
    end

    assign push_cmd  = s3_cmd_reg;
    assign push_load = s3_load_reg;

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_prod_reg  <= s1_prod_next;
            s1_xsum_reg  <= s1_xsum_next;
            s1_first_reg <= item.first_of_string;
            s1_kind_reg  <= s1_kind_next;
            s1_idx_reg   <= s1_idx_next;
        end
        if (adv2)
        begin
            s2_off_reg   <= s2_off_next;
            s2_goff_reg  <= s2_goff_next;
            s2_first_reg <= s1_first_reg;
            s2_kind_reg  <= s1_kind_reg;
        end
        if (adv3)
        begin
            s3_cmd_reg  <= s3_cmd_next;
            s3_load_reg <= s3_load_next;
        end
    end

endmodule

### rtl/tgp_queue.sv
module tgp_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] pop_data
);
    import tgp_pkg::*;

    logic [W-1:0]      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the incoming entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/tgp_back.sv
module tgp_back #(
    parameter int AW = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tgp_pkg::cfg_t    cfg,
    input  logic             queue_empty,
    input  tgp_pkg::cmd_t    pop_cmd,
    input  logic [AW-1:0]    pop_load,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output tgp_pkg::result_t result
);
    import tgp_pkg::*;

    localparam int XW = ((AW > OFF_W) ? AW : OFF_W) + 2;

    logic [AW-1:0] cursor_reg, cursor_next;
    logic [AW-1:0] line_start_reg, line_start_next;
    logic          cursor_wrap_reg, cursor_wrap_next;
    logic          line_wrap_reg, line_wrap_next;
    logic          result_valid_reg, result_valid_next;
    result_t       result_reg, result_next;

    logic [LWB_W-1:0]     lwb;
    logic [NL_STEP_W-1:0] nl_step_reg, nl_step_next;
    logic [STEP8_W-1:0]   step8;

    logic          take;
    logic          emit;
    logic [AW-1:0] cur_in;
    logic [AW-1:0] ls_in;
    logic          cur_wrap_in;
    logic          ls_wrap_in;
    logic [XW-1:0] adv_sum;
    logic [XW-1:0] nl_sum;

    // Newline and glyph steps from the configuration
    assign lwb          = LWB_W'(cfg.line_width) * LWB_W'(cfg.bytes_per_pixel);
    assign nl_step_next = {lwb, 3'b000};
    assign step8        = {cfg.bytes_per_pixel, 3'b000};

    // Take a command when the output register is free or being drained
    assign take = !result_valid_reg || !result_stall;
    assign pop  = !queue_empty && take;
    assign emit = pop && (pop_cmd.kind == KIND_GLYPH);

    always_comb
    begin
        cur_in      = pop_cmd.first ? pop_load           : cursor_reg;
        ls_in       = pop_cmd.first ? pop_load           : line_start_reg;
        cur_wrap_in = pop_cmd.first ? pop_cmd.load_wrap  : cursor_wrap_reg;
        ls_wrap_in  = pop_cmd.first ? pop_cmd.load_wrap  : line_wrap_reg;
        adv_sum     = XW'(cur_in) + XW'(step8);
        nl_sum      = XW'(ls_in) + XW'(nl_step_reg);

        cursor_next      = cursor_reg;
        line_start_next  = line_start_reg;
        cursor_wrap_next = cursor_wrap_reg;
        line_wrap_next   = line_wrap_reg;

        if (pop)
        begin
            unique case (pop_cmd.kind) inside
                KIND_NUL:
                begin
                    cursor_next      = cur_in;
                    line_start_next  = ls_in;
                    cursor_wrap_next = cur_wrap_in;
                    line_wrap_next   = ls_wrap_in;
                end
                KIND_NEWLINE:
                begin
                    line_start_next  = nl_sum[AW-1:0];
                    cursor_next      = nl_sum[AW-1:0];
                    line_wrap_next   = ls_wrap_in || (|nl_sum[XW-1:AW]);
                    cursor_wrap_next = ls_wrap_in || (|nl_sum[XW-1:AW]);
                end
                KIND_SPACE, KIND_GLYPH:
                begin
                    cursor_next      = adv_sum[AW-1:0];
                    cursor_wrap_next = cur_wrap_in || (|adv_sum[XW-1:AW]);
                    line_start_next  = ls_in;
                    line_wrap_next   = ls_wrap_in;
                end
                default:
                begin
                    cursor_next = cursor_reg;
                end
            endcase
        end
    end

    // Build the result from the cursor before it advances
    always_comb
    begin
        result_next.glyph_address    = pop_cmd.glyph_address;
        result_next.dest_address     = OUT_W'(cur_in);
        result_next.address_overflow = pop_cmd.glyph_wrap || cur_wrap_in;
        result_valid_next            = take ? emit : result_valid_reg;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg       <= '0;
            line_start_reg   <= '0;
            cursor_wrap_reg  <= 1'b0;
            line_wrap_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg       <= cursor_next;
            line_start_reg   <= line_start_next;
            cursor_wrap_reg  <= cursor_wrap_next;
            line_wrap_reg    <= line_wrap_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Hold the result until transfer; track the newline step every cycle
    always_ff @(posedge clk)
    begin
        nl_step_reg <= nl_step_next;
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### rtl/text_glyph_placer.sv
// Path: a character taken in passes three front stages, the queue and the output
// register before its result is offered. Throughput: one character per cycle while
// the queue has room; the output register and a four-entry queue let the input keep
// flowing while a result waits to be taken.
// Reset (rst_n, async, active low) clears cursor, line start, wrap marks and all
// valid bits; configuration returns to line width 320, one byte per pixel, bases 0.
module text_glyph_placer #(
    parameter int ADDRESS_WIDTH = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  tgp_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output tgp_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tgp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tgp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tgp_pkg::*;

    localparam int QW = $bits(cmd_t) + ADDRESS_WIDTH;

    cfg_t cfg_reg, cfg_next;

    logic                     push;
    cmd_t                     push_cmd;
    logic [ADDRESS_WIDTH-1:0] push_load;
    logic                     queue_full;
    logic                     queue_empty;
    logic                     pop;
    logic [QW-1:0]            pop_data;
    cmd_t                     pop_cmd;
    logic [ADDRESS_WIDTH-1:0] pop_load;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCREEN_BASE: cfg_next.screen_base     = cfg_data[BASE_W-1:0];
                REG_FONT_BASE:   cfg_next.font_base       = cfg_data[BASE_W-1:0];
                REG_LINE_WIDTH:  cfg_next.line_width      = cfg_data[COORD_W-1:0];
                REG_ORIGIN_X:    cfg_next.origin_x        = cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y:    cfg_next.origin_y        = cfg_data[COORD_W-1:0];
                REG_BPP:         cfg_next.bytes_per_pixel = cfg_data[BPP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_base     <= '0;
            cfg_reg.font_base       <= '0;
            cfg_reg.line_width      <= LINE_WIDTH_RESET;
            cfg_reg.origin_x        <= '0;
            cfg_reg.origin_y        <= '0;
            cfg_reg.bytes_per_pixel <= BPP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept, classify and compute load and glyph addresses
    tgp_front #(
        .AW (ADDRESS_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg        (cfg_reg),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_load  (push_load),
        .queue_full (queue_full)
    );

    // Decouple front and back
    tgp_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cmd, push_load}),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .pop_data  (pop_data)
    );

    assign pop_cmd  = pop_data[QW-1:ADDRESS_WIDTH];
    assign pop_load = pop_data[ADDRESS_WIDTH-1:0];

    // Move the cursor and emit placements
    tgp_back #(
        .AW (ADDRESS_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_empty  (queue_empty),
        .pop_cmd      (pop_cmd),
        .pop_load     (pop_load),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### rtl/tgp_checker.sv
module tgp_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_stall,
    input  tgp_pkg::item_t                 item,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  tgp_pkg::result_t               result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tgp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // A waiting result stays offered
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid
    ) else $error("result dropped while stalled");

    // A waiting result does not change
    a_result_stable: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result)
    ) else $error("result changed while stalled");

    // The input stalls only once an item is held in the first stage
    a_stall_after_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(item_valid && !item_stall)
    ) else $error("input stall without a held item");

    // No result can come out sooner than the pipeline allows after reset
    a_reset_quiet: assert property (
        @(posedge clk)
        !rst_n |=> ##3 !result_valid
    ) else $error("result too soon after reset");

endmodule

bind text_glyph_placer tgp_checker u_tgp_checker (.*);

### dv/tb_text_glyph_placer.sv
module tb_text_glyph_placer;
    import tgp_pkg::*;

    localparam int ADDR_W        = 24;
    localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_W) - 64'd1;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PUNCT_SLOT    = 37;
    localparam int DIGIT_SLOT    = 27;
    localparam int UNKNOWN_SLOT  = 43;
    localparam int PUNCT_COUNT   = 19;
    localparam logic [8*PUNCT_COUNT-1:0] PUNCT_CHARS = "!;:'-.?<>&*()#_=[]|";

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    item_t item;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // receiver control, written by the test sequence only
    logic gaps_on = 1'b1;
    int hold_trigger = 0;
    int hold_cycles = 0;
    // receiver private state
    int hold_seen = 0;
    int hold_left = 0;
    int rx_gap = 0;

    int error_count = 0;
    int cycle_count = 0;

    // placement model state and registers
    logic [63:0] screen_base_m, font_base_m, line_width_m, origin_x_m, origin_y_m, bpp_m;
    logic [63:0] line_start_m, cursor_m;
    logic line_wrap_m, cursor_wrap_m;
    result_t pending_glyphs[$];

    text_glyph_placer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_text_glyph_placer: errors");
            $finish;
        end
    end

    task automatic flag_error(input string what, input logic [23:0] got,
                              input logic [23:0] want);
        $display("%0t %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Font slot of a character code
    function automatic int font_slot(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return c - "A";
        if (c >= "a" && c <= "z") return c - "a";
        if (c >= "0" && c <= "9") return c - "0" + DIGIT_SLOT;
        for (int i = 0; i < PUNCT_COUNT; i++)
            if (c == PUNCT_CHARS[8*(PUNCT_COUNT-1-i) +: 8]) return PUNCT_SLOT + i;
        return UNKNOWN_SLOT;
    endfunction

    // Advance the placement model by one character and queue its glyph, if any
    task automatic place_char(input item_t it);
        logic [63:0] off, sum, g;
        logic w;
        result_t r;
        if (it.first_of_string)
        begin
            off = ((origin_y_m + it.pos_y) * line_width_m + origin_x_m + it.pos_x) * bpp_m;
            sum = screen_base_m + (off & ADDR_MASK);
            w = (sum > ADDR_MASK) || (off > ADDR_MASK);
            cursor_m = sum & ADDR_MASK;
            line_start_m = cursor_m;
            line_wrap_m = w;
            cursor_wrap_m = w;
        end
        if (it.char_code == CHR_NUL) return;
        if (it.char_code == CHR_NEWLINE)
        begin
            sum = line_start_m + 64'd8 * line_width_m * bpp_m;
            line_wrap_m = line_wrap_m || (sum > ADDR_MASK);
            line_start_m = sum & ADDR_MASK;
            cursor_m = line_start_m;
            cursor_wrap_m = line_wrap_m;
            return;
        end
        if (it.char_code != CHR_SPACE)
        begin
            g = font_base_m + 64'(font_slot(it.char_code)) * 64'd8 * bpp_m;
            r.glyph_address = g[23:0];
            r.dest_address = cursor_m[23:0];
            r.address_overflow = (g > ADDR_MASK) || cursor_wrap_m;
            pending_glyphs.push_back(r);
        end
        sum = cursor_m + 64'd8 * bpp_m;
        cursor_wrap_m = cursor_wrap_m || (sum > ADDR_MASK);
        cursor_m = sum & ADDR_MASK;
    endtask

    // Check each glyph transfer against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_glyphs.size() == 0)
                flag_error("unexpected glyph, dest", result.dest_address, '0);
            else
            begin
                want = pending_glyphs.pop_front();
                if (result.glyph_address !== want.glyph_address)
                    flag_error("glyph_address", result.glyph_address, want.glyph_address);
                if (result.dest_address !== want.dest_address)
                    flag_error("dest_address", result.dest_address, want.dest_address);
                if (result.address_overflow !== want.address_overflow)
                    flag_error("address_overflow", 24'(result.address_overflow),
                               24'(want.address_overflow));
            end
        end
    end

    // Drive the output stall: long holds on request, else random gaps
    always @(posedge clk)
    begin
        int unsigned n;
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= hold_cycles;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            result_stall <= 1'b1;
        end
        else if (gaps_on && result_valid && !result_stall)
        begin
            n = $urandom_range(0, 3);
            result_stall <= (n != 0);
            rx_gap <= (n != 0) ? n - 1 : 0;
        end
        else
            result_stall <= gaps_on && ($urandom_range(0, 4) == 0);
    end

    // Offer one character and hold it until the transfer
    task automatic send_char(input item_t it);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        place_char(it);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [23:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        case (r)
            REG_SCREEN_BASE: screen_base_m = 64'(v);
            REG_FONT_BASE:   font_base_m = 64'(v);
            REG_LINE_WIDTH:  line_width_m = 64'(v[11:0]);
            REG_ORIGIN_X:    origin_x_m = 64'(v[11:0]);
            REG_ORIGIN_Y:    origin_y_m = 64'(v[11:0]);
            REG_BPP:         bpp_m = 64'(v[1:0]);
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending, let every glyph come out, then let the pipeline empty
    task automatic quiesce();
        item_valid <= 1'b0;
        while (pending_glyphs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic item_t mk(input logic first, input int x, input int y,
                                 input logic [7:0] c);
        item_t it;
        it.first_of_string = first;
        it.pos_x = x[11:0];
        it.pos_y = y[11:0];
        it.char_code = c;
        return it;
    endfunction

    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) return 8'("A" + $urandom_range(0, 25));
        if (r < 40) return 8'("a" + $urandom_range(0, 25));
        if (r < 55) return 8'("0" + $urandom_range(0, 9));
        if (r < 70) return PUNCT_CHARS[8*$urandom_range(0, PUNCT_COUNT-1) +: 8];
        if (r < 80) return CHR_SPACE;
        if (r < 86) return CHR_NEWLINE;
        if (r < 90) return CHR_NUL;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [23:0] pick_wide();
        case ($urandom_range(0, 3))
            0: return 24'h0;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic program_config(input bit tame);
        if (tame)
        begin
            write_reg(REG_SCREEN_BASE, 24'($urandom_range(0, 24'h0FFFFF)));
            write_reg(REG_FONT_BASE, 24'($urandom_range(0, 24'h0FFFFF)));
            write_reg(REG_LINE_WIDTH, 24'($urandom_range(1, 1024)));
            write_reg(REG_ORIGIN_X, 24'($urandom_range(0, 255)));
            write_reg(REG_ORIGIN_Y, 24'($urandom_range(0, 255)));
            write_reg(REG_BPP, 24'($urandom_range(1, 2)));
        end
        else
        begin
            write_reg(REG_SCREEN_BASE, pick_wide());
            write_reg(REG_FONT_BASE, pick_wide());
            write_reg(REG_LINE_WIDTH, pick_wide());
            write_reg(REG_ORIGIN_X, pick_wide());
            write_reg(REG_ORIGIN_Y, pick_wide());
            write_reg(REG_BPP, 24'($urandom));
        end
    endtask

    // Send strings: mostly a loading item first, then characters, with the odd reload
    task automatic send_text(input int n_items);
        int sent;
        int len;
        int x, y;
        logic first;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 16);
            for (int i = 0; i < len && sent < n_items; i++)
            begin
                if (i == 0)
                    first = ($urandom_range(0, 9) != 0);
                else
                    first = ($urandom_range(0, 19) == 0);
                x = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 63);
                y = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 63);
                send_char(mk(first, x, y, pick_char()));
                sent++;
            end
        end
    endtask

    // Characters after reset with no position loaded
    task automatic test_no_load();
        send_char(mk(0, 0, 0, "H"));
        send_char(mk(0, 4095, 4095, "i"));
        send_char(mk(0, 0, 0, CHR_SPACE));
        send_char(mk(0, 0, 0, CHR_NEWLINE));
        send_char(mk(0, 0, 0, "7"));
    endtask

    // Null, space and newline with and without a load; unknown codes
    task automatic test_special_codes();
        send_char(mk(1, 0, 0, "a"));
        send_char(mk(1, 4095, 4095, CHR_NUL));
        send_char(mk(0, 0, 0, "|"));
        send_char(mk(0, 0, 0, "?"));
        send_char(mk(0, 0, 0, 8'hFF));
        send_char(mk(0, 0, 0, 8'h80));
        send_char(mk(0, 0, 0, CHR_SPACE));
        send_char(mk(0, 0, 0, CHR_NEWLINE));
        send_char(mk(1, 1234, 2345, CHR_SPACE));
        send_char(mk(1, 7, 9, CHR_NEWLINE));
        send_char(mk(0, 0, 0, "b"));
    endtask

    // Largest settings with wrapping loads, then zero width and odd pixel sizes
    task automatic test_config_extremes();
        quiesce();
        write_reg(REG_SCREEN_BASE, 24'hFFFFFF);
        write_reg(REG_FONT_BASE, 24'hFFFFFF);
        write_reg(REG_LINE_WIDTH, 24'hFFF);
        write_reg(REG_ORIGIN_X, 24'hFFF);
        write_reg(REG_ORIGIN_Y, 24'hFFF);
        write_reg(REG_BPP, 24'd3);
        send_char(mk(1, 4095, 4095, "#"));
        send_char(mk(0, 0, 0, "0"));
        send_char(mk(0, 0, 0, CHR_NEWLINE));
        send_char(mk(0, 0, 0, "Z"));
        quiesce();
        write_reg(REG_SCREEN_BASE, 24'h0);
        write_reg(REG_FONT_BASE, 24'h0);
        write_reg(REG_LINE_WIDTH, 24'h0);
        write_reg(REG_ORIGIN_X, 24'h0);
        write_reg(REG_ORIGIN_Y, 24'h0);
        write_reg(REG_BPP, 24'h0);
        send_char(mk(1, 5, 5, "Q"));
        send_char(mk(0, 0, 0, CHR_SPACE));
        send_char(mk(0, 0, 0, CHR_NEWLINE));
        send_char(mk(0, 0, 0, "q"));
        quiesce();
        write_reg(REG_LINE_WIDTH, 24'd1);
        write_reg(REG_BPP, 24'd2);
        send_char(mk(1, 0, 0, "]"));
        send_char(mk(0, 0, 0, CHR_NEWLINE));
    endtask

    // Hold the output for a long stretch while characters keep coming
    task automatic test_output_backpressure();
        quiesce();
        gaps_on <= 1'b0;
        hold_cycles <= 80;
        hold_trigger <= hold_trigger + 1;
        for (int i = 0; i < 40; i++)
            send_char(mk(i == 0, $urandom_range(0, 63), $urandom_range(0, 63),
                         8'("A" + $urandom_range(0, 25))));
        gaps_on <= 1'b1;
    endtask

    // Pause the input until every pending glyph has come out
    task automatic test_sender_pause();
        send_text(20);
        quiesce();
        send_text(20);
    endtask

    // Random text over several register settings
    task automatic test_random_text();
        for (int p = 0; p < 6; p++)
        begin
            quiesce();
            gaps_on <= (p % 3 != 1);
            program_config(p % 2 == 0);
            send_text(210);
        end
    endtask

    initial
    begin
        int waited;
        screen_base_m = 0;
        font_base_m = 0;
        line_width_m = 320;
        origin_x_m = 0;
        origin_y_m = 0;
        bpp_m = 1;
        line_start_m = 0;
        cursor_m = 0;
        line_wrap_m = 1'b0;
        cursor_wrap_m = 1'b0;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SCREEN_BASE;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_load();
        test_special_codes();
        test_config_extremes();
        test_random_text();
        test_output_backpressure();
        test_sender_pause();

        // drain, then watch for stray glyphs
        item_valid <= 1'b0;
        waited = 0;
        while (pending_glyphs.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (pending_glyphs.size() != 0)
            flag_error("glyphs never delivered", 24'(pending_glyphs.size()), '0);
        if (error_count == 0)
            $display("tb_text_glyph_placer: clean");
        else
            $display("tb_text_glyph_placer: errors");
        $finish;
    end

endmodule
